@@ rtl/jmfe_pkg.sv @@
// Shared types, constants and command codes of the JPEG marker frame extractor.
package jmfe_pkg;

    localparam int BUF_BYTES_DEF   = 65536;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] MARK_LEAD = 8'hFF;
    localparam logic [7:0] MARK_SOI  = 8'hD8;
    localparam logic [7:0] MARK_EOI  = 8'hD9;

    localparam logic [16:0] CAP_RESET = 17'd65536;
    localparam int          ADDR_SPAN = 65536;

    // Command codes passed from the front end to the back end.
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_SOI   = 2'd1;
    localparam logic [1:0] K_WRITE = 2'd2;
    localparam logic [1:0] K_DROP  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        done;
        logic [16:0] length;
        logic [31:0] frames;
        logic [31:0] drops;
    } t_cmd;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        frame_done;
        logic [16:0] frame_length;
        logic        frame_dropped;
        logic [31:0] frames_total;
        logic [31:0] drops_total;
        logic        last_of_run;
    } t_out_word;

endpackage

@@ rtl/jmfe_if.sv @@
// Channel interfaces: input byte stream, result stream and capacity register write.
interface jmfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_connection;
    logic       clear_counters;

    modport source (output valid, output data_byte, output new_connection,
                    output clear_counters, input ready);
    modport sink   (input valid, input data_byte, input new_connection,
                    input clear_counters, output ready);
endinterface

interface jmfe_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        frame_done;
    logic [16:0] frame_length;
    logic        frame_dropped;
    logic [31:0] frames_total;
    logic [31:0] drops_total;
    logic        last_of_run;

    modport source (output valid, output write_valid, output write_address,
                    output write_data, output frame_done, output frame_length,
                    output frame_dropped, output frames_total, output drops_total,
                    output last_of_run, input ready);
    modport sink   (input valid, input write_valid, input write_address,
                    input write_data, input frame_done, input frame_length,
                    input frame_dropped, input frames_total, input drops_total,
                    input last_of_run, output ready);
endinterface

interface jmfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] buffer_capacity;

    modport source (output valid, output buffer_capacity, input ready);
    modport sink   (input valid, input buffer_capacity, output ready);
endinterface

@@ rtl/jmfe_front.sv @@
// Front end: accepts stream bytes, tracks frame state and counters, emits commands.
module jmfe_front
    import jmfe_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jmfe_in_if.sink   i_in,
    jmfe_cfg_if.sink  i_cfg,
    input  logic      i_push_ready,
    output logic      o_push_valid,
    output t_cmd      o_push_cmd
);

    localparam int          CAP_LIM   = (BUF_BYTES < ADDR_SPAN) ? BUF_BYTES : ADDR_SPAN;
    localparam logic [16:0] CAP_LIM_V = 17'(CAP_LIM);

    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_prev;
    logic [16:0] r_fill, n_fill;
    logic [31:0] r_frames, n_frames;
    logic [31:0] r_drops, n_drops;
    logic [16:0] r_cap_eff;

    logic        accept;
    logic        cur_in_frame;
    logic [7:0]  cur_prev;
    logic [16:0] cur_fill;
    logic [16:0] fill_inc;
    logic [31:0] cur_frames;
    logic [31:0] cur_drops;
    t_cmd        cmd;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_push_ready;
    assign accept      = i_in.valid && i_push_ready;

    always_comb begin
        cur_frames   = i_in.clear_counters ? 32'd0 : r_frames;
        cur_drops    = i_in.clear_counters ? 32'd0 : r_drops;
        cur_in_frame = i_in.new_connection ? 1'b0 : r_in_frame;
        cur_prev     = i_in.new_connection ? 8'd0 : r_prev;
        cur_fill     = i_in.new_connection ? 17'd0 : r_fill;
        fill_inc     = cur_fill + 17'd1;

        n_in_frame = cur_in_frame;
        n_fill     = cur_fill;
        n_frames   = cur_frames;
        n_drops    = cur_drops;

        cmd        = '0;
        cmd.kind   = K_NONE;

        if (!cur_in_frame) begin
            if (i_in.data_byte == MARK_SOI && cur_prev == MARK_LEAD) begin
                n_in_frame = 1'b1;
                n_fill     = 17'd2;
                cmd.kind   = K_SOI;
            end
        end else if (cur_fill >= r_cap_eff) begin
            n_in_frame = 1'b0;
            n_drops    = cur_drops + 32'd1;
            cmd.kind   = K_DROP;
        end else begin
            n_fill   = fill_inc;
            cmd.kind = K_WRITE;
            cmd.addr = cur_fill[15:0];
            cmd.data = i_in.data_byte;
            if (i_in.data_byte == MARK_EOI && cur_prev == MARK_LEAD) begin
                n_in_frame = 1'b0;
                n_frames   = cur_frames + 32'd1;
                cmd.done   = 1'b1;
                cmd.length = fill_inc;
            end
        end

        cmd.frames = n_frames;
        cmd.drops  = n_drops;
    end

    assign o_push_valid = accept && (cmd.kind != K_NONE);
    assign o_push_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_prev     <= 8'd0;
            r_fill     <= 17'd0;
            r_frames   <= 32'd0;
            r_drops    <= 32'd0;
            r_cap_eff  <= (CAP_RESET > CAP_LIM_V) ? CAP_LIM_V : CAP_RESET;
        end else begin
            if (accept) begin
                r_in_frame <= n_in_frame;
                r_prev     <= i_in.data_byte;
                r_fill     <= n_fill;
                r_frames   <= n_frames;
                r_drops    <= n_drops;
            end
            // The saturated capacity is settled here so the byte path sees one compare.
            if (i_cfg.valid) begin
                r_cap_eff <= (i_cfg.buffer_capacity > CAP_LIM_V) ? CAP_LIM_V
                                                                  : i_cfg.buffer_capacity;
            end
        end
    end

endmodule

@@ rtl/jmfe_queue.sv @@
// Short command queue between the front end and the back end.
module jmfe_queue
    import jmfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop
);

    localparam int            AW       = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != (AW + 1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    // Pointers wrap at the last entry so any depth works, not only powers of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (AW + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (AW + 1)'(1);
            end
        end
    end

endmodule

@@ rtl/jmfe_back.sv @@
// Back end: turns queued commands into result words through an output register.
module jmfe_back
    import jmfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    jmfe_out_if.source o_out
);

    logic      r_valid;
    logic      r_pend;
    t_out_word r_word;
    t_out_word n_word;
    logic      load;

    assign load    = !r_valid || o_out.ready;
    assign o_q_pop = load && !r_pend && i_q_valid;

    always_comb begin
        n_word              = '0;
        n_word.frames_total = i_q_cmd.frames;
        n_word.drops_total  = i_q_cmd.drops;
        unique case (i_q_cmd.kind)
            K_SOI: begin
                n_word.write_valid   = 1'b1;
                n_word.write_address = 16'd0;
                n_word.write_data    = MARK_LEAD;
                n_word.last_of_run   = 1'b0;
            end
            K_DROP: begin
                n_word.frame_dropped = 1'b1;
                n_word.last_of_run   = 1'b1;
            end
            default: begin
                n_word.write_valid   = 1'b1;
                n_word.write_address = i_q_cmd.addr;
                n_word.write_data    = i_q_cmd.data;
                n_word.frame_done    = i_q_cmd.done;
                n_word.frame_length  = i_q_cmd.length;
                n_word.last_of_run   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_q_valid;
                r_pend  <= i_q_valid && (i_q_cmd.kind == K_SOI);
            end
        end
    end

    // The second start-of-image word keeps the counts of the first one.
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_word.write_address <= 16'd1;
                r_word.write_data    <= MARK_SOI;
                r_word.last_of_run   <= 1'b1;
            end else if (i_q_valid) begin
                r_word <= n_word;
            end
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.write_valid   = r_word.write_valid;
    assign o_out.write_address = r_word.write_address;
    assign o_out.write_data    = r_word.write_data;
    assign o_out.frame_done    = r_word.frame_done;
    assign o_out.frame_length  = r_word.frame_length;
    assign o_out.frame_dropped = r_word.frame_dropped;
    assign o_out.frames_total  = r_word.frames_total;
    assign o_out.drops_total   = r_word.drops_total;
    assign o_out.last_of_run   = r_word.last_of_run;

endmodule

@@ rtl/jpeg_marker_frame_extractor.sv @@
// Top level of the JPEG marker frame extractor: front end, command queue, back end.
//
//  channel   modport  payload                                          word moves when
//  i_in      sink     data_byte, new_connection, clear_counters         valid & ready
//  o_out     source   write and frame fields, counters, last_of_run     valid & ready
//  i_cfg     sink     buffer_capacity                                   valid & ready
//
// One input byte is accepted per cycle; ready drops only when the command queue is full.
// A start-of-image byte yields two result words, so the back end presents both before
// it pops the next command; the queue absorbs that hold. A result word passes through
// the command queue and the back end's output register. Reset (synchronous, active low)
// clears frame state, counters and the queue and sets the capacity to 65536, or to
// BUF_BYTES if that is smaller. Output stalls hold the word.
module jpeg_marker_frame_extractor
    import jmfe_pkg::*;
#(
    parameter int BUF_BYTES   = BUF_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jmfe_in_if.sink    i_in,
    jmfe_cfg_if.sink   i_cfg,
    jmfe_out_if.source o_out
);

    logic push_valid;
    logic push_ready;
    t_cmd push_cmd;
    logic pop_valid;
    t_cmd pop_cmd;
    logic pop;

    jmfe_front #(
        .BUF_BYTES (BUF_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    jmfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    jmfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .i_q_cmd   (pop_cmd),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    // A word without a buffer write can only be a drop report, and it ends its run.
    a_nowrite_is_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.write_valid) |-> (o_out.frame_dropped && o_out.last_of_run))
        else $error("result without write is not a drop report");

    // A completed frame reports a length one past the address of its last byte.
    a_done_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done) |->
            (o_out.write_valid && o_out.last_of_run &&
             o_out.frame_length == {1'b0, o_out.write_address} + 17'd1))
        else $error("frame length does not match final address");

    // The first start-of-image word is followed at once by the write to address 1.
    a_soi_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_of_run) |=>
            (o_out.valid && o_out.write_address == 16'd1 &&
             o_out.write_data == MARK_SOI && o_out.last_of_run))
        else $error("start-of-image pair broken");
`endif

endmodule
